@@ design/gjmi_pkg.sv @@
// package: widths, sequencer states and a helper function for the matrix inverse core
`default_nettype none
package gjmi_pkg;
	localparam int MaxOrder  = 8;
	localparam int OrdW      = 4;
	localparam int IdxW      = 3;                  // row / column index
	localparam int ColW      = 4;                  // augmented column index
	localparam int AddrW     = 7;                  // row*16 + col
	localparam int EntW      = 48;
	localparam int FracBits  = 16;
	localparam int CntW      = 7;
	localparam logic [EntW-1:0] Mag48 = {1'b0, {(EntW-1){1'b1}}};
	localparam logic [EntW-1:0] OneQ  = 48'h1_0000;

	typedef enum logic [3:0] {
		ST_LOAD, ST_FILL, ST_PRD, ST_MRD, ST_MDIV, ST_URD, ST_UMUL, ST_UWR,
		ST_CHK, ST_ORD, ST_ODIV, ST_OUT
	} gjmi_state_t;

	function automatic logic [EntW-1:0] sgn48(input logic [EntW-1:0] m, input logic neg);
		logic [EntW-1:0] c;
		c = (m > Mag48) ? Mag48 : m;
		return neg ? (~c + 1'b1) : c;
	endfunction
endpackage
`default_nettype wire

@@ design/gjmi_if.sv @@
// item channel: valid/ready handshake with a 32-bit payload and flags
`default_nettype none
interface gjmi_if;
	logic        valid;
	logic        ready;
	logic [31:0] element;
	logic        singular;
	logic        last;
	modport source (output valid, element, singular, last, input ready);
	modport sink   (input valid, element, singular, last, output ready);
endinterface
`default_nettype wire

@@ design/gjmi_div.sv @@
// shared restoring divider: (|num| << 16) / |den|, one quotient bit per cycle, saturated
`default_nettype none
module gjmi_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [gjmi_pkg::EntW-1:0] num,
	input  wire logic [gjmi_pkg::EntW-1:0] den,
	output logic done,
	output logic [gjmi_pkg::EntW-1:0] quo
);
	import gjmi_pkg::*;
	localparam int NumW = EntW + FracBits;  // 64-bit dividend
	localparam int StW  = 7;

	logic [NumW-1:0] dvd_q;
	logic [NumW-1:0] quo_q;
	logic [EntW:0]   rem_q;
	logic [EntW-1:0] dsr_q;
	logic            neg_q;
	logic            zero_q;
	logic [StW-1:0]  step_q;
	logic            done_q;
	logic [EntW:0]   trial;
	logic [EntW:0]   shifted;
	logic [EntW-1:0] nmag;
	logic [EntW-1:0] dmag;

	assign nmag = num[EntW-1] ? (~num + 1'b1) : num;
	assign dmag = den[EntW-1] ? (~den + 1'b1) : den;
	assign shifted = {rem_q[EntW-1:0], dvd_q[NumW-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= StW'(NumW);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				if (step_q == StW'(1)) done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {nmag, {FracBits{1'b0}}};
			dsr_q  <= dmag;
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= num[EntW-1] ^ den[EntW-1];
			zero_q <= (den == '0);
		end else if (step_q != '0) begin
			dvd_q <= {dvd_q[NumW-2:0], 1'b0};
			if (!trial[EntW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = zero_q ? '0 :
		sgn48((quo_q[NumW-1:EntW] != '0) ? Mag48 : quo_q[EntW-1:0], neg_q);
endmodule
`default_nettype wire

@@ design/gjmi_mul.sv @@
// registered Q32.16 multiply with saturation, split into 24-bit partial products
`default_nettype none
module gjmi_mul (
	input  wire logic clk,
	input  wire logic [gjmi_pkg::EntW-1:0] a,
	input  wire logic [gjmi_pkg::EntW-1:0] b,
	output logic [gjmi_pkg::EntW-1:0] prod
);
	import gjmi_pkg::*;
	localparam int HW = 24;

	logic [EntW-1:0] ua;
	logic [EntW-1:0] ub;
	logic [2*HW-1:0] hh_s1;
	logic [2*HW-1:0] hl_s1;
	logic [2*HW-1:0] lh_s1;
	logic [2*HW-1:0] ll_s1;
	logic            neg_s1;
	logic [2*HW:0]   mid;
	logic [63:0]     s;
	logic [63:0]     t;
	logic [63:0]     sum;
	logic            ovf;

	assign ua = a[EntW-1] ? (~a + 1'b1) : a;
	assign ub = b[EntW-1] ? (~b + 1'b1) : b;

	// partial products
	always_ff @(posedge clk) begin
		hh_s1  <= ua[EntW-1:HW] * ub[EntW-1:HW];
		hl_s1  <= ua[EntW-1:HW] * ub[HW-1:0];
		lh_s1  <= ua[HW-1:0] * ub[EntW-1:HW];
		ll_s1  <= ua[HW-1:0] * ub[HW-1:0];
		neg_s1 <= a[EntW-1] ^ b[EntW-1];
	end

	// combine and saturate
	always_comb begin
		mid = {1'b0, hl_s1} + {1'b0, lh_s1};
		s   = {hh_s1[15:0], 48'b0};
		t   = {mid[39:0], 24'b0};
		sum = s + t + {16'b0, ll_s1};
		ovf = (hh_s1 >= 48'(1 << 15)) || (mid >= 49'(64'h80_0000_0000)) ||
			(t >= (64'h8000_0000_0000_0000 - s));
		prod = sgn48(ovf ? Mag48 : sum[63:FracBits], neg_s1);
	end
endmodule
`default_nettype wire

@@ design/gauss_jordan_matrix_inverse_core.sv @@
// top level: augmented store, elimination sequencer, shared divider and multiplier
`default_nettype none
// Gauss-Jordan inverse of an order x order signed Q16.16 matrix (order 1..8, reset 2).
// Elements come in row-major, one per accepted item, while the core is loading.
// After the last element the core stops accepting and runs elimination without
// row exchange through one shared 64-step restoring divider and one multiplier with
// one register stage, with one store entry read or written per cycle. Each division
// first reads its operand from the store, and each row update steps through the
// augmented columns (2*order columns), reading the pivot row entry, then the target
// and pivot row entries for the multiplier, then writing the result; each inverse item
// reads the diagonal and the augmented entry, divides, then outputs. A zero multiplier
// skips its row update. A singular matrix yields one item with singular set; otherwise
// order^2 inverse items follow, last set on the final one. Writing order while loading
// restarts loading.
module gauss_jordan_matrix_inverse_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [gjmi_pkg::OrdW-1:0] cfg_data,
	gjmi_if.sink   in_ch,
	gjmi_if.source out_ch
);
	import gjmi_pkg::*;

	gjmi_state_t st_q, st_d;
	logic [OrdW-1:0] order_q;
	logic [IdxW:0]   n;
	logic [CntW-1:0] cnt_q;
	logic [IdxW-1:0] lr_q, lc_q;   // load row / column
	logic [IdxW-1:0] piv_q, row_q; // pivot column, target row
	logic [ColW-1:0] col_q;
	logic [EntW-1:0] mem [0:(1<<AddrW)-1];
	logic [EntW-1:0] rd_q;
	logic [EntW-1:0] piv_val_q, m_q, a_q;
	logic [AddrW-1:0] raddr;
	logic            we;
	logic [AddrW-1:0] waddr;
	logic [EntW-1:0] wdata;
	logic            rd_phase_q;
	logic            sing_q;
	logic [31:0]     out_q;
	logic            ovalid_q, olast_q, osing_q;
	logic            div_start, div_done;
	logic [EntW-1:0] dnum, dden, quo, prod;
	logic [EntW:0]   diff;
	logic [EntW-1:0] upd;
	logic            last_col, last_row;

	assign n = (order_q == '0) ? 4'd1 : (order_q > OrdW'(MaxOrder)) ? 4'(MaxOrder) : {1'b0,order_q[IdxW-1:0]} | {order_q[IdxW],3'b0};
	assign last_col = ({1'b0, lc_q} == n - 1'b1);
	assign last_row = ({1'b0, lr_q} == n - 1'b1);

	gjmi_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .num(dnum), .den(dden),
		.done(div_done), .quo(quo));
	gjmi_mul u_mul (.clk(clk), .a(rd_q), .b(m_q), .prod(prod));

	// store
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// state register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD; order_q <= OrdW'(2); lr_q <= '0; lc_q <= '0;
			piv_q <= '0; row_q <= '0; col_q <= '0; cnt_q <= '0;
			rd_phase_q <= 1'b0; sing_q <= 1'b0; ovalid_q <= 1'b0; olast_q <= 1'b0;
			osing_q <= 1'b0; out_q <= '0; piv_val_q <= '0; m_q <= '0; a_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				order_q <= cfg_data; lr_q <= '0; lc_q <= '0;
			end
			if (out_ch.ready) ovalid_q <= 1'b0;
			case (st_q)
			ST_LOAD: if (in_ch.valid && !cfg_we) begin
				lc_q <= last_col ? '0 : lc_q + 1'b1;
				if (last_col) lr_q <= last_row ? '0 : lr_q + 1'b1;
				if (last_col && last_row) begin
					row_q <= '0; col_q <= '0;
				end
			end
			ST_FILL: begin
				col_q <= ({1'b0,col_q[IdxW-1:0]} == n - 1'b1) ? '0 : col_q + 1'b1;
				if ({1'b0,col_q[IdxW-1:0]} == n - 1'b1) begin
					row_q <= row_q + 1'b1;
					if ({1'b0,row_q} == n - 1'b1) begin
						piv_q <= '0; row_q <= '0;
					end
				end
			end
			ST_PRD: if (rd_phase_q) piv_val_q <= rd_q;
			ST_MDIV: if (div_done) m_q <= quo;
			ST_UMUL: if (cnt_q == CntW'(1)) a_q <= rd_q;
			ST_UWR: col_q <= col_q + 1'b1;
			ST_CHK: begin
				if (rd_phase_q && rd_q == '0) sing_q <= 1'b1;
				if (rd_phase_q) row_q <= row_q + 1'b1;
				if (rd_phase_q && {1'b0,row_q} == n - 1'b1) begin
					row_q <= '0; col_q <= '0;
				end
			end
			ST_ORD: if (rd_phase_q && cnt_q == CntW'(1)) piv_val_q <= rd_q;
			ST_OUT: if (!ovalid_q || out_ch.ready) begin
				ovalid_q <= 1'b1;
				osing_q <= sing_q;
				if (sing_q) begin
					out_q <= '0; olast_q <= 1'b1;
				end else begin
					out_q <= ($signed(quo) > 48'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
						($signed(quo) < -48'sh8000_0000) ? 32'h8000_0000 : quo[31:0];
					olast_q <= ({1'b0,row_q} == n - 1'b1) && ({1'b0,col_q[IdxW-1:0]} == n - 1'b1);
					col_q <= ({1'b0,col_q[IdxW-1:0]} == n - 1'b1) ? '0 : col_q + 1'b1;
					if ({1'b0,col_q[IdxW-1:0]} == n - 1'b1) row_q <= row_q + 1'b1;
				end
			end
			default: ;
			endcase
			// phase and step counters
			case (st_q)
			ST_PRD, ST_MRD, ST_URD, ST_CHK, ST_ORD: rd_phase_q <= (st_d == st_q) ? !rd_phase_q : 1'b0;
			default: rd_phase_q <= 1'b0;
			endcase
			if (st_d != st_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
			// after pivot read / multiplier / row loop bookkeeping
			if (st_q == ST_UWR && col_q == ColW'(2*n - 1)) begin
				row_q <= row_q + 1'b1;
				col_q <= '0;
			end
			if (st_q == ST_MDIV && div_done && quo == '0) row_q <= row_q + 1'b1;
			// pivot row skips its own update, next row starts with a fresh read
			if (st_q == ST_MRD && row_q == piv_q) begin
				row_q <= row_q + 1'b1;
				rd_phase_q <= 1'b0;
			end
			if (st_q == ST_PRD && rd_phase_q && rd_q == '0) piv_q <= piv_q + 1'b1;
			if (st_d == ST_PRD && st_q != ST_PRD && st_q != ST_FILL) begin
				piv_q <= piv_q + 1'b1; row_q <= '0;
			end
			if (st_d == ST_CHK && st_q != ST_CHK) begin
				row_q <= '0; sing_q <= 1'b0;
			end
			if (st_q == ST_OUT && st_d == ST_LOAD) begin
				sing_q <= 1'b0; row_q <= '0; col_q <= '0;
			end
		end
	end

	// row update result
	assign diff = {a_q[EntW-1], a_q} - {prod[EntW-1], prod};
	assign upd  = ($signed(diff) > $signed({1'b0, Mag48})) ? Mag48 :
		($signed(diff) < -$signed({1'b0, Mag48})) ? (~Mag48 + 1'b1) : diff[EntW-1:0];

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
		ST_LOAD: if (in_ch.valid && !cfg_we && last_col && last_row) st_d = ST_FILL;
		ST_FILL: if ({1'b0,col_q[IdxW-1:0]} == n - 1'b1 && {1'b0,row_q} == n - 1'b1) st_d = ST_PRD;
		ST_PRD: if (rd_phase_q) begin
			if (rd_q == '0) st_d = ({1'b0,piv_q} == n - 1'b1) ? ST_CHK : ST_PRD;
			else st_d = ST_MRD;
		end
		ST_MRD: if (row_q == piv_q) st_d = ({1'b0,row_q} == n - 1'b1) ?
				(({1'b0,piv_q} == n - 1'b1) ? ST_CHK : ST_PRD) : ST_MRD;
			else if (rd_phase_q) st_d = ST_MDIV;
		ST_MDIV: if (div_done) st_d = (quo == '0) ?
				(({1'b0,row_q} == n - 1'b1) ? (({1'b0,piv_q} == n - 1'b1) ? ST_CHK : ST_PRD) : ST_MRD)
				: ST_URD;
		ST_URD: if (rd_phase_q) st_d = ST_UMUL;
		ST_UMUL: if (cnt_q == CntW'(2)) st_d = ST_UWR;
		ST_UWR: if (col_q == ColW'(2*n - 1))
				st_d = ({1'b0,row_q} == n - 1'b1) ? (({1'b0,piv_q} == n - 1'b1) ? ST_CHK : ST_PRD) : ST_MRD;
			else st_d = ST_URD;
		ST_CHK: if (rd_phase_q && {1'b0,row_q} == n - 1'b1)
				st_d = (sing_q || rd_q == '0) ? ST_OUT : ST_ORD;
		ST_ORD: if (cnt_q == CntW'(3)) st_d = ST_ODIV;
		ST_ODIV: if (div_done) st_d = ST_OUT;
		ST_OUT: if (!ovalid_q || out_ch.ready)
			st_d = (sing_q || (({1'b0,row_q} == n - 1'b1) && ({1'b0,col_q[IdxW-1:0]} == n - 1'b1)))
				? ST_LOAD : ST_ORD;
		default: st_d = ST_LOAD;
		endcase
	end

	// outputs and store access
	always_comb begin
		raddr = '0; we = 1'b0; waddr = '0; wdata = '0;
		div_start = 1'b0; dnum = rd_q; dden = piv_val_q;
		case (st_q)
		ST_LOAD: begin
			we = in_ch.valid && !cfg_we;
			waddr = {lr_q, 1'b0, lc_q};
			wdata = {{(EntW-32){in_ch.element[31]}}, in_ch.element};
		end
		ST_FILL: begin
			we = 1'b1;
			waddr = {row_q, ColW'(n) + col_q};
			wdata = (row_q == col_q[IdxW-1:0]) ? OneQ : '0;
		end
		ST_PRD: raddr = {piv_q, 1'b0, piv_q};
		ST_MRD: begin
			raddr = {row_q, 1'b0, piv_q};
			div_start = rd_phase_q && row_q != piv_q;
		end
		ST_URD: raddr = {piv_q, col_q};
		// target entry first, then the pivot row entry again for the multiplier
		ST_UMUL: raddr = (cnt_q == CntW'(0)) ? {row_q, col_q} : {piv_q, col_q};
		ST_UWR: begin
			we = 1'b1; waddr = {row_q, col_q}; wdata = upd;
		end
		ST_CHK: raddr = {row_q, 1'b0, row_q};
		ST_ORD: begin
			raddr = (cnt_q == CntW'(0) || cnt_q == CntW'(1)) ? {row_q, 1'b0, row_q}
				: {row_q, ColW'(n) + col_q};
			div_start = (cnt_q == CntW'(3));
		end
		default: ;
		endcase
	end

	assign in_ch.ready     = (st_q == ST_LOAD) && !cfg_we;
	assign out_ch.valid    = ovalid_q;
	assign out_ch.element  = out_q;
	assign out_ch.singular = osing_q;
	assign out_ch.last     = olast_q;
endmodule
`default_nettype wire
